// ===== hw/rtl/bgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

    // Width of the tick counter and the internal time stamps
    localparam int TIME_BITS = 32;

    localparam int OUT_TIME_W = 32;

    // Action codes
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_LONG       = 4'd8;
    localparam logic [3:0] ACT_CLICK_LONG = 4'd9;
    localparam logic [3:0] ACT_LOCK       = 4'd10;
    localparam logic [3:0] ACT_UNLOCK     = 4'd11;

    localparam logic [7:0] MAX_REPORT_CLICKS = 8'd7;
    localparam logic [7:0] EARLY_CLICKS      = 8'd5;
    localparam logic [7:0] LOCK_ARM_CLICKS   = 8'd3;
    localparam logic [15:0] EARLY_GAP_MS     = 16'd250;

    // Register reset values
    localparam logic [7:0]  DEBOUNCE_RST     = 8'd20;
    localparam logic [15:0] MIN_PRESS_RST    = 16'd30;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd800;
    localparam logic [15:0] MULTI_WIN_RST    = 16'd400;
    localparam logic [15:0] FAILSAFE_RST     = 16'd10000;
    localparam logic [15:0] LOCK_WIN_RST     = 16'd1200;
    localparam logic [15:0] LOCK_HOLD_RST    = 16'd2000;
    localparam logic [15:0] UNLOCK_HOLD_RST  = 16'd3000;

    typedef enum logic [2:0] {
        REG_DEBOUNCE_COUNT  = 3'd0,
        REG_MIN_PRESS       = 3'd1,
        REG_LONG_PRESS      = 3'd2,
        REG_MULTI_WINDOW    = 3'd3,
        REG_FAILSAFE_HOLD   = 3'd4,
        REG_LOCK_WINDOW     = 3'd5,
        REG_LOCK_HOLD       = 3'd6,
        REG_UNLOCK_HOLD     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  debounce_count;
        logic [15:0] min_press_ms;
        logic [15:0] long_press_ms;
        logic [15:0] multi_click_window_ms;
        logic [15:0] failsafe_hold_ms;
        logic [15:0] lock_window_ms;
        logic [15:0] lock_hold_ms;
        logic [15:0] unlock_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic                  restart_request;
        logic [OUT_TIME_W-1:0] input_time;
        logic [7:0]            pending_clicks;
        logic                  pressed_status;
        logic [3:0]            action;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire bgd_pkg::cfg_idx_t index,
    input  wire logic [15:0]       data,
    output bgd_pkg::cfg_t          cfg
);
    import bgd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_count        <= DEBOUNCE_RST;
            cfg_reg.min_press_ms          <= MIN_PRESS_RST;
            cfg_reg.long_press_ms         <= LONG_PRESS_RST;
            cfg_reg.multi_click_window_ms <= MULTI_WIN_RST;
            cfg_reg.failsafe_hold_ms      <= FAILSAFE_RST;
            cfg_reg.lock_window_ms        <= LOCK_WIN_RST;
            cfg_reg.lock_hold_ms          <= LOCK_HOLD_RST;
            cfg_reg.unlock_hold_ms        <= UNLOCK_HOLD_RST;
        end
        else if (wr_en)
        begin
            case (index)
                REG_DEBOUNCE_COUNT: cfg_reg.debounce_count        <= data[7:0];
                REG_MIN_PRESS:      cfg_reg.min_press_ms          <= data;
                REG_LONG_PRESS:     cfg_reg.long_press_ms         <= data;
                REG_MULTI_WINDOW:   cfg_reg.multi_click_window_ms <= data;
                REG_FAILSAFE_HOLD:  cfg_reg.failsafe_hold_ms      <= data;
                REG_LOCK_WINDOW:    cfg_reg.lock_window_ms        <= data;
                REG_LOCK_HOLD:      cfg_reg.lock_hold_ms          <= data;
                REG_UNLOCK_HOLD:    cfg_reg.unlock_hold_ms        <= data;
                default:            cfg_reg                       <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bgd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bgd_pkg::cfg_t   cfg,
    input  wire logic            step,
    input  wire logic            btn_level,
    output bgd_pkg::result_t     result
);
    import bgd_pkg::*;

    localparam int TW = TIME_BITS;

    logic [TW-1:0] time_reg,        time_next;
    logic [7:0]    integ_reg,       integ_next;
    logic          deb_reg,         deb_next;
    logic          prev_reg,        prev_next;
    logic [7:0]    click_reg,       click_next;
    logic [TW-1:0] press_reg,       press_next;
    logic [TW-1:0] release_reg,     release_next;
    logic          long_reg,        long_next;
    logic [7:0]    lock_total_reg,  lock_total_next;
    logic [TW-1:0] lock_start_reg,  lock_start_next;
    logic          lsv_reg,         lsv_next;
    logic          armed_reg,       armed_next;
    logic          fs_reg,          fs_next;
    logic [TW-1:0] last_reg,        last_next;

    logic [TW-1:0] now;
    logic [TW-1:0] held;
    logic [TW-1:0] gap;
    logic [TW-1:0] elapsed;
    logic          lock_done;
    logic          restart;
    logic          status;
    logic [3:0]    action;

    assign now = time_reg;

    always_comb
    begin
        time_next       = time_reg + TW'(1);
        integ_next      = integ_reg;
        deb_next        = deb_reg;
        prev_next       = prev_reg;
        click_next      = click_reg;
        press_next      = press_reg;
        release_next    = release_reg;
        long_next       = long_reg;
        lock_total_next = lock_total_reg;
        lock_start_next = lock_start_reg;
        lsv_next        = lsv_reg;
        armed_next      = armed_reg;
        fs_next         = fs_reg;
        last_next       = last_reg;
        held            = '0;
        gap             = '0;
        elapsed         = '0;
        lock_done       = 1'b0;
        restart         = 1'b0;
        action          = ACT_NONE;

        // integrator debounce; a counter above full scale only counts down
        if (btn_level)
        begin
            if (integ_next != 8'd0)
                integ_next = integ_next - 8'd1;
        end
        else if (integ_next < cfg.debounce_count)
        begin
            integ_next = integ_next + 8'd1;
        end
        if (integ_next == 8'd0)
            deb_next = 1'b1;
        else if (integ_next == cfg.debounce_count)
            deb_next = 1'b0;

        status = deb_next;

        if (deb_next && !prev_reg)
        begin
            press_next = now;
            long_next  = 1'b0;
            last_next  = now;
            armed_next = (lock_total_reg == LOCK_ARM_CLICKS);
            fs_next    = 1'b0;
        end

        held = now - press_next;

        if (!deb_next && prev_reg)
        begin
            if (fs_next)
            begin
                click_next = 8'd0;
                fs_next    = 1'b0;
            end
            if (long_next)
            begin
                click_next = 8'd0;
                long_next  = 1'b0;
                armed_next = 1'b0;
            end
            else if (held >= TW'(cfg.min_press_ms))
            begin
                gap = now - lock_start_next;
                if (!lsv_next || gap > TW'(cfg.lock_window_ms))
                begin
                    lock_total_next = 8'd0;
                    lock_start_next = now;
                    lsv_next        = 1'b1;
                end
                if (armed_next && held >= TW'(cfg.lock_hold_ms))
                begin
                    action = (held >= TW'(cfg.unlock_hold_ms)) ? ACT_UNLOCK : ACT_LOCK;
                    lock_total_next = 8'd0;
                    lock_start_next = '0;
                    lsv_next        = 1'b0;
                    armed_next      = 1'b0;
                    click_next      = 8'd0;
                    lock_done       = 1'b1;
                end
                else
                begin
                    if (!armed_next)
                        lock_total_next = lock_total_next + 8'd1;
                    click_next   = click_next + 8'd1;
                    release_next = now;
                    last_next    = now;
                end
            end
        end

        if (lock_done)
        begin
            prev_next = deb_next;
        end
        else
        begin
            // no long press while armed for a lock gesture
            if (deb_next && !long_next && held >= TW'(cfg.long_press_ms) && !armed_next)
            begin
                action     = (click_next == 8'd0) ? ACT_LONG : ACT_CLICK_LONG;
                click_next = 8'd0;
                last_next  = now;
                long_next  = 1'b1;
            end

            if (deb_next && !fs_next && cfg.failsafe_hold_ms != 16'd0 &&
                held >= TW'(cfg.failsafe_hold_ms))
            begin
                fs_next    = 1'b1;
                click_next = 8'd0;
                status     = 1'b0;
                last_next  = now;
                restart    = 1'b1;
            end

            if (!restart)
            begin
                if (!deb_next && click_next != 8'd0)
                begin
                    elapsed = now - release_next;
                    if (elapsed >= TW'(cfg.multi_click_window_ms) ||
                        (click_next >= EARLY_CLICKS && elapsed >= TW'(EARLY_GAP_MS)))
                    begin
                        // runs of eight or more are dropped silently
                        if (click_next <= MAX_REPORT_CLICKS)
                        begin
                            action    = click_next[3:0];
                            last_next = now;
                        end
                        click_next = 8'd0;
                    end
                end
                prev_next = deb_next;
            end
        end

        result.action          = action;
        result.pressed_status  = status;
        result.pending_clicks  = click_next;
        result.input_time      = OUT_TIME_W'(last_next);
        result.restart_request = restart;

        // restart clears all gesture state, the integrator to the configured scale; registers untouched
        if (restart)
        begin
            time_next       = '0;
            integ_next      = cfg.debounce_count;
            deb_next        = 1'b0;
            prev_next       = 1'b0;
            click_next      = 8'd0;
            press_next      = '0;
            release_next    = '0;
            long_next       = 1'b0;
            lock_total_next = 8'd0;
            lock_start_next = '0;
            lsv_next        = 1'b0;
            armed_next      = 1'b0;
            fs_next         = 1'b0;
            last_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg       <= '0;
            integ_reg      <= DEBOUNCE_RST;
            deb_reg        <= 1'b0;
            prev_reg       <= 1'b0;
            click_reg      <= 8'd0;
            press_reg      <= '0;
            release_reg    <= '0;
            long_reg       <= 1'b0;
            lock_total_reg <= 8'd0;
            lock_start_reg <= '0;
            lsv_reg        <= 1'b0;
            armed_reg      <= 1'b0;
            fs_reg         <= 1'b0;
            last_reg       <= '0;
        end
        else if (step)
        begin
            time_reg       <= time_next;
            integ_reg      <= integ_next;
            deb_reg        <= deb_next;
            prev_reg       <= prev_next;
            click_reg      <= click_next;
            press_reg      <= press_next;
            release_reg    <= release_next;
            long_reg       <= long_next;
            lock_total_reg <= lock_total_next;
            lock_start_reg <= lock_start_next;
            lsv_reg        <= lsv_next;
            armed_reg      <= armed_next;
            fs_reg         <= fs_next;
            last_reg       <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/button_gesture_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                    | Payload
// s_axis   | in  | s_axis_tvalid/s_axis_tready  | tick item, tdata[0] btn_level
// m_axis   | out | m_axis_tvalid/m_axis_tready  | one result item per tick item
// cfg      | in  | cfg_wr_en (no wait)          | cfg_index, cfg_data
//
// One tick item per clock cycle sustained while m_axis_tready stays high; each item
// passes an input register, the gesture logic and a result register, and its result
// item is valid once the result register takes it. The rate is set by the gesture
// state update. Reset clears all gesture state and loads the register defaults.
// A stalled result register holds its item and stalls the input register,
// which keeps one more item; s_axis_tready drops only when both are full.

module button_gesture_decoder_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [0] btn_level
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // [3:0] action, [4] pressed_status, [12:5] pending_clicks,
    // [44:13] input_time, [45] restart_request
    output logic [47:0]            m_axis_tdata,
    input  wire logic              cfg_wr_en,
    input  wire bgd_pkg::cfg_idx_t cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import bgd_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_valid_reg;
    logic    in_raw_reg;
    logic    advance;
    logic    step;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    bgd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    bgd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .btn_level (in_raw_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_raw_reg <= s_axis_tdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg.restart_request, out_reg.input_time,
                            out_reg.pending_clicks, out_reg.pressed_status, out_reg.action};

    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed item did not reach the result register");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_raw_reg))
        else $error("stalled input item lost");

    a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.restart_request |->
            !out_reg.pressed_status && out_reg.pending_clicks == 8'd0)
        else $error("restart result carries stale status");

    a_lock_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.action == ACT_LOCK || out_reg.action == ACT_UNLOCK) |->
            out_reg.pending_clicks == 8'd0 && !out_reg.restart_request)
        else $error("lock gesture left clicks pending");

    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.action <= ACT_UNLOCK)
        else $error("action code out of range");

endmodule

`default_nettype wire

// ===== test/button_gesture_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module button_gesture_decoder_unit_test;
    import bgd_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int SQUEEZE_CYCLES = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [0] btn_level
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] action, [4] pressed_status, [12:5] pending_clicks,
    // [44:13] input_time, [45] restart_request
    logic [47:0] m_axis_tdata;
    logic        cfg_wr_en = 1'b0;
    cfg_idx_t    cfg_index = REG_DEBOUNCE_COUNT;
    logic [15:0] cfg_data = '0;

    button_gesture_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gesture predictor state
    cfg_t model_cfg = '{DEBOUNCE_RST, MIN_PRESS_RST, LONG_PRESS_RST, MULTI_WIN_RST,
                        FAILSAFE_RST, LOCK_WIN_RST, LOCK_HOLD_RST, UNLOCK_HOLD_RST};
    logic [TIME_BITS-1:0] tick_now = '0;
    logic [TIME_BITS-1:0] press_start = '0;
    logic [TIME_BITS-1:0] release_time = '0;
    logic [TIME_BITS-1:0] lock_start = '0;
    logic [TIME_BITS-1:0] last_input = '0;
    logic [7:0] integ = DEBOUNCE_RST;
    logic [7:0] click_total = '0;
    logic [7:0] arm_clicks = '0;
    logic       btn_down = 1'b0;
    logic       btn_down_q = 1'b0;
    logic       long_sent = 1'b0;
    logic       lock_open = 1'b0;
    logic       armed = 1'b0;
    logic       failsafe_hit = 1'b0;

    bit      pending_ticks[$];
    result_t expected_results[$];

    int idle_pct = 20;
    int mismatch_count = 0;
    int ticks_sent = 0;
    int results_checked = 0;
    int settings_loaded = 0;
    int restarts_seen = 0;
    int action_tally[16];
    int stall_cycles = 0;
    int stall_left = 0;
    bit squeeze_done = 1'b0;

    function automatic result_t decode_tick(input logic raw);
        logic [TIME_BITS-1:0] held, since;
        result_t r;
        logic restart;
        r = '0;
        restart = 1'b0;

        // up/down integrator; with a zero scale both ends meet and pressed wins
        if (raw)
        begin
            if (integ != 8'd0) integ = integ - 8'd1;
        end
        else if (integ < model_cfg.debounce_count)
        begin
            integ = integ + 8'd1;
        end
        if (integ == 8'd0) btn_down = 1'b1;
        else if (integ == model_cfg.debounce_count) btn_down = 1'b0;
        r.pressed_status = btn_down;

        if (btn_down && !btn_down_q)
        begin
            press_start = tick_now;
            long_sent = 1'b0;
            last_input = tick_now;
            armed = (arm_clicks == LOCK_ARM_CLICKS);
            failsafe_hit = 1'b0;
        end

        if (!btn_down && btn_down_q)
        begin
            held = tick_now - press_start;
            if (failsafe_hit)
            begin
                click_total = '0;
                failsafe_hit = 1'b0;
            end
            if (long_sent)
            begin
                click_total = '0;
                long_sent = 1'b0;
                armed = 1'b0;
            end
            else if (held >= model_cfg.min_press_ms)
            begin
                since = tick_now - lock_start;
                if (!lock_open || since > model_cfg.lock_window_ms)
                begin
                    arm_clicks = '0;
                    lock_start = tick_now;
                    lock_open = 1'b1;
                end
                // lock gesture ends the tick right here
                if (armed && held >= model_cfg.lock_hold_ms)
                begin
                    r.action = (held >= model_cfg.unlock_hold_ms) ? ACT_UNLOCK : ACT_LOCK;
                    arm_clicks = '0;
                    lock_start = '0;
                    lock_open = 1'b0;
                    armed = 1'b0;
                    click_total = '0;
                    btn_down_q = btn_down;
                    tick_now = tick_now + 32'd1;
                    r.input_time = last_input;
                    return r;
                end
                if (!armed) arm_clicks = arm_clicks + 8'd1;
                click_total = click_total + 8'd1;
                release_time = tick_now;
                last_input = tick_now;
            end
        end

        held = tick_now - press_start;
        if (btn_down && !long_sent && !armed && held >= model_cfg.long_press_ms)
        begin
            r.action = (click_total == 8'd0) ? ACT_LONG : ACT_CLICK_LONG;
            click_total = '0;
            last_input = tick_now;
            long_sent = 1'b1;
        end

        if (btn_down && !failsafe_hit && model_cfg.failsafe_hold_ms != 16'd0 &&
            held >= model_cfg.failsafe_hold_ms)
        begin
            failsafe_hit = 1'b1;
            click_total = '0;
            r.pressed_status = 1'b0;
            last_input = tick_now;
            restart = 1'b1;
        end

        if (!restart)
        begin
            since = tick_now - release_time;
            if (!btn_down && click_total != 8'd0 &&
                (since >= model_cfg.multi_click_window_ms ||
                 (click_total >= EARLY_CLICKS && since >= EARLY_GAP_MS)))
            begin
                // runs of eight or more are dropped silently
                if (click_total <= MAX_REPORT_CLICKS)
                begin
                    r.action = click_total[3:0];
                    last_input = tick_now;
                end
                click_total = '0;
            end
            btn_down_q = btn_down;
        end

        r.pending_clicks = click_total;
        r.input_time = last_input;
        r.restart_request = restart;

        if (restart)
        begin
            tick_now = '0;
            press_start = '0;
            release_time = '0;
            lock_start = '0;
            last_input = '0;
            integ = model_cfg.debounce_count;
            click_total = '0;
            arm_clicks = '0;
            btn_down = 1'b0;
            btn_down_q = 1'b0;
            long_sent = 1'b0;
            lock_open = 1'b0;
            armed = 1'b0;
            failsafe_hit = 1'b0;
        end
        else
        begin
            tick_now = tick_now + 32'd1;
        end
        return r;
    endfunction

    task automatic hold_level(input bit lvl, input int n);
        repeat (n) pending_ticks.push_back(lvl);
    endtask

    task automatic add_click(input int press, input int gap);
        hold_level(1'b1, press);
        hold_level(1'b0, gap);
    endtask

    task automatic queue_gesture(input cfg_t c);
        int db, press, span, quiet, n, hold;
        db = int'(c.debounce_count);
        press = db + int'(c.min_press_ms) + int'($urandom_range(0, 2));
        span = int'(c.multi_click_window_ms) - db - 1;
        if (span < 0) span = 0;
        quiet = db + int'(c.multi_click_window_ms) + int'($urandom_range(2, 6));
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(8, 10))
                                                : int'($urandom_range(1, 7));
                repeat (n) add_click(press, db + int'($urandom_range(0, span)));
            end
            4: hold_level(1'b1, db + int'(c.long_press_ms) + int'($urandom_range(0, 4)));
            5:
            begin
                add_click(press, db + int'($urandom_range(0, span)));
                hold_level(1'b1, int'(c.long_press_ms) + int'($urandom_range(0, 4)));
            end
            6, 7:
            begin
                // sometimes let the lock window go stale first
                if ($urandom_range(0, 1) != 0)
                    hold_level(1'b0, db + int'(c.lock_window_ms) + 1);
                repeat (3) add_click(press, db + int'($urandom_range(0, 2)));
                hold = ($urandom_range(0, 1) != 0) ? int'(c.unlock_hold_ms)
                                                   : int'(c.lock_hold_ms);
                hold_level(1'b1, hold + int'($urandom_range(0, 3)));
            end
            8: hold_level(1'b1, ((c.failsafe_hold_ms != 16'd0) ? int'(c.failsafe_hold_ms)
                                                               : int'(c.long_press_ms))
                                + int'($urandom_range(0, 5)));
            default: repeat ($urandom_range(3, 12))
                hold_level(1'($urandom_range(0, 1)), int'($urandom_range(1, 2 * db + 2)));
        endcase
        hold_level(1'b0, quiet);
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        c.debounce_count = 8'($urandom_range(1, 4));
        c.min_press_ms = 16'($urandom_range(0, 4));
        c.long_press_ms = 16'($urandom_range(12, 30));
        c.multi_click_window_ms = 16'($urandom_range(6, 20));
        c.failsafe_hold_ms = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(40, 90));
        c.lock_window_ms = 16'($urandom_range(30, 80));
        c.lock_hold_ms = 16'($urandom_range(10, 40));
        c.unlock_hold_ms = c.lock_hold_ms + 16'($urandom_range(1, 20));
        return c;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(REG_DEBOUNCE_COUNT, {8'd0, c.debounce_count});
        write_reg(REG_MIN_PRESS, c.min_press_ms);
        write_reg(REG_LONG_PRESS, c.long_press_ms);
        write_reg(REG_MULTI_WINDOW, c.multi_click_window_ms);
        write_reg(REG_FAILSAFE_HOLD, c.failsafe_hold_ms);
        write_reg(REG_LOCK_WINDOW, c.lock_window_ms);
        write_reg(REG_LOCK_HOLD, c.lock_hold_ms);
        write_reg(REG_UNLOCK_HOLD, c.unlock_hold_ms);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_cfg = c;
        settings_loaded++;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // tick driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(decode_tick(s_axis_tdata[0]));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    s_axis_tdata <= {7'd0, pending_ticks.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_check
        result_t got, want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[45:0]);
                results_checked++;
                action_tally[got.action]++;
                if (got.restart_request) restarts_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: %h", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, got.action);
                        mismatch_count++;
                    end
                    if (got.pressed_status !== want.pressed_status)
                    begin
                        $error("pressed_status: expected %0d, got %0d",
                               want.pressed_status, got.pressed_status);
                        mismatch_count++;
                    end
                    if (got.pending_clicks !== want.pending_clicks)
                    begin
                        $error("pending_clicks: expected %0d, got %0d",
                               want.pending_clicks, got.pending_clicks);
                        mismatch_count++;
                    end
                    if (got.input_time !== want.input_time)
                    begin
                        $error("input_time: expected %0d, got %0d",
                               want.input_time, got.input_time);
                        mismatch_count++;
                    end
                    if (got.restart_request !== want.restart_request)
                    begin
                        $error("restart_request: expected %0d, got %0d",
                               want.restart_request, got.restart_request);
                        mismatch_count++;
                    end
                end
            end
            // one long hold-off while plenty of ticks are queued, so the input backs up
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!squeeze_done && results_checked > 100 && pending_ticks.size() > 200)
            begin
                squeeze_done <= 1'b1;
                stall_left <= SQUEEZE_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            cfg_wr_en)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == STALL_LIMIT)
        begin
            $error("no item moved for %0d cycles", STALL_LIMIT);
            $display("button_gesture_decoder_unit_test: done, errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        cfg_t c;
        int click_reports;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one slow single click
        hold_level(1'b1, 60);
        hold_level(1'b0, 450);
        wait_idle();

        // every click count, short press, long, click-long, lock, unlock, failsafe
        c = '{8'd2, 16'd3, 16'd12, 16'd8, 16'd40, 16'd40, 16'd20, 16'd30};
        load_settings(c);
        for (int n = 1; n <= 8; n++)
        begin
            repeat (n) add_click(5, 4);
            hold_level(1'b0, 12);
        end
        add_click(2, 12);
        add_click(16, 12);
        add_click(5, 4);
        add_click(16, 12);
        hold_level(1'b0, 45);
        repeat (3) add_click(5, 4);
        add_click(24, 12);
        hold_level(1'b0, 45);
        repeat (3) add_click(5, 4);
        add_click(33, 12);
        add_click(45, 12);
        wait_idle();

        // early report of five clicks after the short gap
        c = '{8'd1, 16'd1, 16'd200, 16'd260, 16'd0, 16'd5, 16'd100, 16'd150};
        load_settings(c);
        repeat (5) add_click(2, 2);
        hold_level(1'b0, 256);
        wait_idle();

        // zero integrator scale: always pressed, long press then restart
        c = '{8'd0, 16'd0, 16'd5, 16'd4, 16'd15, 16'd10, 16'd3, 16'd4};
        load_settings(c);
        repeat (40) pending_ticks.push_back(1'($urandom_range(0, 1)));
        wait_idle();

        for (int p = 0; p < 2; p++)
        begin
            c = random_settings();
            load_settings(c);
            idle_pct <= (p == 1) ? 0 : 20;
            while (pending_ticks.size() < 150) queue_gesture(c);
            wait_idle();
        end

        click_reports = 0;
        for (int a = 1; a <= 7; a++) click_reports += action_tally[a];
        $display("Covered %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_loaded, results_checked);
        $display("Seen: %0d click runs, %0d long, %0d click-long, %0d lock, %0d unlock,",
                 click_reports, action_tally[ACT_LONG], action_tally[ACT_CLICK_LONG],
                 action_tally[ACT_LOCK], action_tally[ACT_UNLOCK]);
        $display("      %0d restarts", restarts_seen);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("button_gesture_decoder_unit_test: done, clean");
        end
        else
        begin
            $display("button_gesture_decoder_unit_test: done, errors");
        end
        $finish;
    end

endmodule
